// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file pli_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define PLI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interpolator check failed");

// Next-cycle implication, disabled while rst is high.
`define PLI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interpolator check failed");

`endif

// File: rtl/pli_pkg.sv
`timescale 1ns / 1ps
package pli_pkg;

   localparam int MAX_POINTS = 64;
   localparam int PTR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DATA_W     = 16;
   localparam int DIV_STEPS  = DATA_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_POINTS);

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_FULL  = 2'd1;
   localparam logic [1:0] STS_EMPTY = 2'd2;
   localparam logic [1:0] STS_ORDER = 2'd3;

   typedef struct packed {
      logic cap_en;
      logic exec_en;
      logic scan_en;
      logic mult_en;
      logic div_en;
      logic sign_en;
      logic out_load;
   } pli_cmd_type;

   typedef struct packed {
      logic go_scan;
      logic scan_more;
      logic scan_interp;
      logic div_last;
   } pli_stat_type;

endpackage

// File: rtl/pli_ctrl.sv
`timescale 1ns / 1ps
module pli_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pli_pkg::pli_stat_type stat,
   output pli_pkg::pli_cmd_type  cmd
);
   import pli_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EXEC   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_MULT   = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_SIGN   = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap_en = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec_en = 1'b1;
            state_in    = stat.go_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (!stat.scan_more) begin
               state_in = stat.scan_interp ? S_MULT : S_FINISH;
            end
         end
         S_MULT: begin
            cmd.mult_en = 1'b1;
            state_in    = S_DIV;
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            if (stat.div_last) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            cmd.sign_en = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/pli_datapath.sv
`timescale 1ns / 1ps
module pli_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_command,
   input  logic signed [15:0]   req_x_pos,
   input  logic signed [15:0]   req_y_level,
   input  pli_pkg::pli_cmd_type cmd,
   output pli_pkg::pli_stat_type stat,
   output logic signed [15:0]   rsp_level,
   output logic [1:0]           rsp_status
);
   import pli_pkg::*;

   logic [1:0]               cmd_ff;
   logic signed [DATA_W-1:0] q_ff;
   logic signed [DATA_W-1:0] yin_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] last_x_ff;

   logic signed [DATA_W-1:0] mem_x [MAX_POINTS];
   logic signed [DATA_W-1:0] mem_y [MAX_POINTS];
   logic signed [DATA_W-1:0] rd_x_ff, rd_y_ff;

   logic [PTR_W-1:0]         scan_idx_ff, scan_idx_in;
   logic signed [DATA_W-1:0] prev_x_ff, prev_y_ff;

   logic signed [DATA_W-1:0] y1_ff;
   logic                     neg_ff;
   logic [DATA_W-1:0]        dy_mag_ff, dq_mag_ff, den_ff;

   logic [DATA_W-1:0]        rem_ff, sh_ff;
   logic [DIV_CNT_W-1:0]     div_cnt_ff;

   logic signed [DATA_W-1:0] res_level_ff, rsp_level_ff;
   logic [1:0]               res_status_ff, rsp_status_ff;

   logic                     full, order_bad, wr_en;
   logic                     below, idx_has_next;
   logic [CNT_W-1:0]         idx_next_w;
   logic signed [DATA_W:0]   dy;
   logic [DATA_W:0]          dq, den, div_t, div_diff;
   logic                     div_ge;
   logic [DATA_W+1:0]        quo_s, sum;

   assign full      = (count_ff == MAX_COUNT);
   assign order_bad = (count_ff != '0) && (q_ff < last_x_ff);
   assign wr_en     = cmd.exec_en && (cmd_ff == CMD_ADD) && !full && !order_bad;

   assign below        = (rd_x_ff < q_ff);
   assign idx_next_w   = {1'b0, scan_idx_ff} + CNT_W'(1);
   assign idx_has_next = (idx_next_w < count_ff);

   assign stat.go_scan     = (cmd_ff == CMD_QUERY) && (count_ff != '0);
   assign stat.scan_more   = below && idx_has_next;
   assign stat.scan_interp = !below && (scan_idx_ff != '0) && (rd_x_ff != q_ff);
   assign stat.div_last    = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // segment deltas; q lies strictly between x1 and x2 here
   assign dy  = {rd_y_ff[DATA_W-1], rd_y_ff} - {prev_y_ff[DATA_W-1], prev_y_ff};
   assign dq  = {q_ff[DATA_W-1], q_ff} - {prev_x_ff[DATA_W-1], prev_x_ff};
   assign den = {rd_x_ff[DATA_W-1], rd_x_ff} - {prev_x_ff[DATA_W-1], prev_x_ff};

   // restoring step; the quotient fits 16 bits since q - x1 < x2 - x1
   assign div_t    = {rem_ff, sh_ff[DATA_W-1]};
   assign div_ge   = (div_t >= {1'b0, den_ff});
   assign div_diff = div_t - {1'b0, den_ff};

   assign quo_s = neg_ff ? ((DATA_W+2)'(0) - {2'b00, sh_ff}) : {2'b00, sh_ff};
   assign sum   = {{2{y1_ff[DATA_W-1]}}, y1_ff} + quo_s;

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.cap_en) begin
         scan_idx_in = '0;
      end else if (cmd.scan_en && stat.scan_more) begin
         scan_idx_in = idx_next_w[PTR_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.exec_en && (cmd_ff == CMD_CLEAR)) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // breakpoint store: write on add, read always at the next scan index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[count_ff[PTR_W-1:0]] <= q_ff;
         mem_y[count_ff[PTR_W-1:0]] <= yin_ff;
      end
      rd_x_ff <= mem_x[scan_idx_in];
      rd_y_ff <= mem_y[scan_idx_in];
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (cmd.cap_en) begin
         cmd_ff <= req_command;
         q_ff   <= req_x_pos;
         yin_ff <= req_y_level;
      end
      if (wr_en) begin
         last_x_ff <= q_ff;
      end

      if (cmd.exec_en) begin
         res_level_ff <= '0;
         case (cmd_ff)
            CMD_ADD: begin
               if (full) begin
                  res_status_ff <= STS_FULL;
               end else if (order_bad) begin
                  res_status_ff <= STS_ORDER;
               end else begin
                  res_status_ff <= STS_OK;
               end
            end
            CMD_QUERY: begin
               if (count_ff == '0) begin
                  res_status_ff <= STS_EMPTY;
               end else begin
                  res_status_ff <= STS_OK;
               end
            end
            default: begin
               res_status_ff <= STS_OK;
            end
         endcase
      end

      if (cmd.scan_en) begin
         if (stat.scan_more) begin
            prev_x_ff <= rd_x_ff;
            prev_y_ff <= rd_y_ff;
         end else begin
            res_level_ff  <= rd_y_ff;
            res_status_ff <= STS_OK;
            y1_ff         <= prev_y_ff;
            neg_ff        <= dy[DATA_W];
            dy_mag_ff     <= dy[DATA_W] ? DATA_W'((DATA_W+1)'(0) - dy) : dy[DATA_W-1:0];
            dq_mag_ff     <= dq[DATA_W-1:0];
            den_ff        <= den[DATA_W-1:0];
         end
      end

      if (cmd.mult_en) begin
         {rem_ff, sh_ff} <= dy_mag_ff * dq_mag_ff;
         div_cnt_ff      <= '0;
      end else if (cmd.div_en) begin
         rem_ff     <= div_ge ? div_diff[DATA_W-1:0] : div_t[DATA_W-1:0];
         sh_ff      <= {sh_ff[DATA_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.sign_en) begin
         res_level_ff <= sum[DATA_W-1:0];
      end

      if (cmd.out_load) begin
         rsp_level_ff  <= res_level_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_level  = rsp_level_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: rtl/piecewise_linear_interpolator.sv
// Piecewise linear lookup table of up to 64 breakpoints in non-decreasing x.
// A request clears the table, appends a breakpoint or queries a level, and
// gives exactly one response. Clear, add, an empty query and the unused
// command pass from the execute state through the finish state to the
// response register. A query scans the breakpoint memory one entry per
// cycle from the start until the answer is known, after 1 to 64 entries;
// when it falls between two breakpoints, a 16x16 multiply step, 16 steps
// of the restoring divider and a sign-fix step follow. One request is
// worked on at a time; the next is taken while a finished response still
// waits to be collected.
`timescale 1ns / 1ps
module piecewise_linear_interpolator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_x_pos,
   input  logic signed [15:0] req_y_level,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_level,
   output logic [1:0]         rsp_status
);
   import pli_pkg::*;

   pli_cmd_type  cmd;
   pli_stat_type stat;

   pli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pli_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_command),
      .req_x_pos   (req_x_pos),
      .req_y_level (req_y_level),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_level   (rsp_level),
      .rsp_status  (rsp_status)
   );

endmodule

// File: rtl/pli_check.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pli_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_level,
   input logic [1:0]         rsp_status
);
   import pli_pkg::*;

   // nothing pending comes out of reset
   `PLI_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   // one request at a time: busy right after taking one
   `PLI_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // a failed request (status other than OK) reports level zero
   `PLI_ASSERT_IMP(a_err_level_zero, clock, reset, rsp_valid && rsp_status != STS_OK, rsp_level == 16'sd0)

   `PLI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind piecewise_linear_interpolator pli_check u_pli_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_level  (rsp_level),
   .rsp_status (rsp_status)
);
